>>> hdl/row_column_wipe_pattern_macros.svh
// assertion helpers for the wipe pattern block
`ifndef ROW_COLUMN_WIPE_PATTERN_MACROS_SVH
`define ROW_COLUMN_WIPE_PATTERN_MACROS_SVH

// same-cycle implication
`define RCWP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rcwp_pkg.sv
`timescale 1ns / 1ps

package rcwp_pkg;

  localparam int unsigned MAX_ROWS      = 256;
  localparam int unsigned MAX_COLS      = 256;

  localparam int unsigned TIME_W        = 64;
  localparam int unsigned COORD_W       = 8;
  localparam int unsigned LEVEL_W       = 8;
  localparam int unsigned NUM_LEVELS    = 4;
  localparam int unsigned SECS_W        = 16;
  localparam int unsigned PCT_W         = 7;
  localparam int unsigned COUNT_REG_W   = 9;

  localparam int unsigned US_PER_SECOND = 1000000;
  localparam int unsigned DUR_W         = 36;

  localparam int unsigned PCT_FULL      = 100;
  localparam int unsigned ROUND_HALF    = 50;
  localparam int unsigned PROD_W        = 15;
  localparam int unsigned RECIP_W       = 28;
  localparam int unsigned SCALE_RECIP   = 5243;
  localparam int unsigned SCALE_SHIFT   = 19;

  localparam int unsigned CFG_ADDR_W    = 5;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned IN_DATA_W     = 80;
  localparam int unsigned OUT_DATA_W    = 40;

  typedef enum logic [2:0] {
    REG_DURATION = 3'd0,
    REG_BRIGHT   = 3'd1,
    REG_RED      = 3'd2,
    REG_GREEN    = 3'd3,
    REG_BLUE     = 3'd4,
    REG_WHITE    = 3'd5,
    REG_ROWS     = 3'd6,
    REG_COLS     = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    REQ_RESTART = 1'b0,
    REQ_PIXEL   = 1'b1
  } req_type_e;

endpackage

>>> hdl/row_column_wipe_pattern.sv
`timescale 1ns / 1ps

// Wipe pattern pixel generator. A restart transaction (tuser 0) is taken
// without leaving idle and resets the sweep to row-down at the given time. A
// pixel transaction (tuser 1) goes from idle through the elapsed, clip and
// multiply states to the output state, where an in-range result is registered,
// and the next transaction is taken once the block is back in idle. The
// multipliers are MW bits wide, MW being the larger of 9 and the bit width of
// the row and column limits. The time goes into a bit-serial shift-add unit
// that forms clip*N and (coordinate+1)*D one multiplier bit per cycle, and the
// pixel's state is read from comparing the two products. One pixel is in work
// at a time; a finished result waits in the output register while the next
// transaction is accepted, and a second finished result holds the input off
// until the first one leaves. Pixels outside the configured matrix give no
// result but still take part in the end-of-frame phase check.
module row_column_wipe_pattern
  import rcwp_pkg::*;
#(
  parameter int unsigned MaxRows = MAX_ROWS,
  parameter int unsigned MaxCols = MAX_COLS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // now_us[63:0], pixel_row, pixel_col
  input  logic                  s_axis_tuser,  // req_type
  input  logic                  s_axis_tlast,  // frame_last
  // pixel stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // lit, red, green, blue, white, zero pad
  output logic                  m_axis_tuser,  // sweep_phase
  output logic                  m_axis_tlast   // frame_end
);

  localparam int unsigned RW     = $clog2(MaxRows + 1);
  localparam int unsigned CLW    = $clog2(MaxCols + 1);
  localparam int unsigned KW     = COORD_W + 1;
  localparam int unsigned MW0    = (RW > CLW) ? RW : CLW;
  localparam int unsigned MW     = (MW0 > KW) ? MW0 : KW;
  localparam int unsigned CNT_W  = $clog2(MW);
  localparam int unsigned ACC_W  = DUR_W + MW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ELAP = 5'b00010,
    S_CLIP = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic                  phase_q, phase_d;
  logic [TIME_W-1:0]     begin_q, begin_d;
  logic                  m_valid_q, m_valid_d;

  logic [SECS_W-1:0]      secs_q, secs_d;
  logic [PCT_W-1:0]       bright_q, bright_d;
  logic [LEVEL_W-1:0]     level_q [NUM_LEVELS];
  logic [LEVEL_W-1:0]     level_d [NUM_LEVELS];
  logic [COUNT_REG_W-1:0] rows_q, rows_d;
  logic [COUNT_REG_W-1:0] cols_q, cols_d;

  logic [TIME_W-1:0]      now_q, now_d;
  logic [COORD_W-1:0]     row_q, row_d;
  logic [COORD_W-1:0]     col_q, col_d;
  logic                   last_q, last_d;
  logic [DUR_W-1:0]       dur_q, dur_d;
  logic [TIME_W-1:0]      elapsed_q, elapsed_d;
  logic                   expired_q, expired_d;
  logic [PROD_W-1:0]      prod_q [NUM_LEVELS];
  logic [PROD_W-1:0]      prod_d [NUM_LEVELS];
  logic [LEVEL_W-1:0]     scaled_q [NUM_LEVELS];
  logic [LEVEL_W-1:0]     scaled_d [NUM_LEVELS];
  logic [ACC_W-1:0]       mcand_a_q, mcand_a_d;
  logic [ACC_W-1:0]       mcand_b_q, mcand_b_d;
  logic [ACC_W-1:0]       acc_a_q, acc_a_d;
  logic [ACC_W-1:0]       acc_b_q, acc_b_d;
  logic [MW-1:0]          nbits_q, nbits_d;
  logic [MW-1:0]          kbits_q, kbits_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   out_lit_q, out_lit_d;
  logic [LEVEL_W-1:0]     out_level_q [NUM_LEVELS];
  logic [LEVEL_W-1:0]     out_level_d [NUM_LEVELS];
  logic                   out_phase_q, out_phase_d;
  logic                   out_last_q, out_last_d;

  logic                   cfg_wr;
  logic                   in_fire;
  logic [RW-1:0]          rows_eff;
  logic [CLW-1:0]         cols_eff;
  logic [PCT_W-1:0]       pct;
  logic [SECS_W-1:0]      secs_eff;
  logic [DUR_W-1:0]       clip;
  logic                   in_range;
  logic                   lit;
  logic                   out_free;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // effective counts: zero reads as one, saturate at the limit
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RW'(1);
    end else if (32'(rows_q) > MaxRows) begin
      rows_eff = RW'(MaxRows);
    end else begin
      rows_eff = RW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CLW'(1);
    end else if (32'(cols_q) > MaxCols) begin
      cols_eff = CLW'(MaxCols);
    end else begin
      cols_eff = CLW'(cols_q);
    end
  end

  assign pct      = (32'(bright_q) > PCT_FULL) ? PCT_W'(PCT_FULL) : bright_q;
  assign secs_eff = (secs_q == '0) ? SECS_W'(1) : secs_q;
  assign clip     = (elapsed_q >= TIME_W'(dur_q)) ? dur_q : elapsed_q[DUR_W-1:0];
  assign in_range = (32'(row_q) < 32'(rows_eff)) && (32'(col_q) < 32'(cols_eff));
  assign lit      = phase_q ? (acc_a_q >= acc_b_q) : (acc_a_q < acc_b_q);

  // register read
  always_comb begin
    prdata = '0;
    case (cfg_reg_e'(paddr[CFG_ADDR_W-1:2]))
      REG_DURATION: prdata = CFG_DATA_W'(secs_q);
      REG_BRIGHT:   prdata = CFG_DATA_W'(bright_q);
      REG_RED:      prdata = CFG_DATA_W'(level_q[0]);
      REG_GREEN:    prdata = CFG_DATA_W'(level_q[1]);
      REG_BLUE:     prdata = CFG_DATA_W'(level_q[2]);
      REG_WHITE:    prdata = CFG_DATA_W'(level_q[3]);
      REG_ROWS:     prdata = CFG_DATA_W'(rows_q);
      REG_COLS:     prdata = CFG_DATA_W'(cols_q);
      default:      prdata = '0;
    endcase
  end

  // register write
  always_comb begin
    secs_d   = secs_q;
    bright_d = bright_q;
    level_d  = level_q;
    rows_d   = rows_q;
    cols_d   = cols_q;
    if (cfg_wr) begin
      case (cfg_reg_e'(paddr[CFG_ADDR_W-1:2]))
        REG_DURATION: secs_d     = pwdata[SECS_W-1:0];
        REG_BRIGHT:   bright_d   = pwdata[PCT_W-1:0];
        REG_RED:      level_d[0] = pwdata[LEVEL_W-1:0];
        REG_GREEN:    level_d[1] = pwdata[LEVEL_W-1:0];
        REG_BLUE:     level_d[2] = pwdata[LEVEL_W-1:0];
        REG_WHITE:    level_d[3] = pwdata[LEVEL_W-1:0];
        REG_ROWS:     rows_d     = pwdata[COUNT_REG_W-1:0];
        REG_COLS:     cols_d     = pwdata[COUNT_REG_W-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    begin_d     = begin_q;
    m_valid_d   = m_valid_q & ~m_axis_tready;
    now_d       = now_q;
    row_d       = row_q;
    col_d       = col_q;
    last_d      = last_q;
    dur_d       = dur_q;
    elapsed_d   = elapsed_q;
    expired_d   = expired_q;
    prod_d      = prod_q;
    scaled_d    = scaled_q;
    mcand_a_d   = mcand_a_q;
    mcand_b_d   = mcand_b_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    nbits_d     = nbits_q;
    kbits_d     = kbits_q;
    cnt_d       = cnt_q;
    out_lit_d   = out_lit_q;
    out_level_d = out_level_q;
    out_phase_d = out_phase_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          now_d  = s_axis_tdata[TIME_W-1:0];
          row_d  = s_axis_tdata[TIME_W +: COORD_W];
          col_d  = s_axis_tdata[TIME_W+COORD_W +: COORD_W];
          last_d = s_axis_tlast;
          dur_d  = DUR_W'(secs_eff) * DUR_W'(US_PER_SECOND);
          if (req_type_e'(s_axis_tuser) == REQ_RESTART) begin
            phase_d = 1'b0;
            begin_d = s_axis_tdata[TIME_W-1:0];
          end else begin
            state_d = S_ELAP;
          end
        end
      end
      S_ELAP: begin
        elapsed_d = now_q - begin_q;
        for (int i = 0; i < NUM_LEVELS; i++) begin
          prod_d[i] = PROD_W'(level_q[i]) * PROD_W'(pct) + PROD_W'(ROUND_HALF);
        end
        state_d = S_CLIP;
      end
      S_CLIP: begin
        // divide by 100 through a reciprocal, exact over the product range
        for (int i = 0; i < NUM_LEVELS; i++) begin
          scaled_d[i] = LEVEL_W'((RECIP_W'(prod_q[i]) * RECIP_W'(SCALE_RECIP))
                                 >> SCALE_SHIFT);
        end
        expired_d = (elapsed_q >= TIME_W'(dur_q));
        mcand_a_d = ACC_W'(clip);
        mcand_b_d = ACC_W'(dur_q);
        acc_a_d   = '0;
        acc_b_d   = '0;
        if (phase_q) begin
          nbits_d = MW'(cols_eff);
          kbits_d = MW'(col_q) + MW'(1);
        end else begin
          nbits_d = MW'(rows_eff);
          kbits_d = MW'(row_q) + MW'(1);
        end
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        // one multiplier bit per cycle for clip*n and (k+1)*dur
        if (nbits_q[0]) begin
          acc_a_d = acc_a_q + mcand_a_q;
        end
        if (kbits_q[0]) begin
          acc_b_d = acc_b_q + mcand_b_q;
        end
        mcand_a_d = mcand_a_q << 1;
        mcand_b_d = mcand_b_q << 1;
        nbits_d   = nbits_q >> 1;
        kbits_d   = kbits_q >> 1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!in_range || out_free) begin
          if (in_range) begin
            m_valid_d   = 1'b1;
            out_lit_d   = lit;
            for (int i = 0; i < NUM_LEVELS; i++) begin
              out_level_d[i] = lit ? scaled_q[i] : '0;
            end
            out_phase_d = phase_q;
            out_last_d  = last_q;
          end
          if (last_q && expired_q) begin
            begin_d = now_q;
            phase_d = ~phase_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= 1'b0;
      begin_q    <= '0;
      m_valid_q  <= 1'b0;
      secs_q     <= SECS_W'(1);
      bright_q   <= PCT_W'(PCT_FULL);
      level_q[0] <= '1;
      level_q[1] <= '1;
      level_q[2] <= '1;
      level_q[3] <= '0;
      rows_q     <= COUNT_REG_W'(1);
      cols_q     <= COUNT_REG_W'(1);
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      begin_q   <= begin_d;
      m_valid_q <= m_valid_d;
      secs_q    <= secs_d;
      bright_q  <= bright_d;
      level_q   <= level_d;
      rows_q    <= rows_d;
      cols_q    <= cols_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    row_q       <= row_d;
    col_q       <= col_d;
    last_q      <= last_d;
    dur_q       <= dur_d;
    elapsed_q   <= elapsed_d;
    expired_q   <= expired_d;
    prod_q      <= prod_d;
    scaled_q    <= scaled_d;
    mcand_a_q   <= mcand_a_d;
    mcand_b_q   <= mcand_b_d;
    acc_a_q     <= acc_a_d;
    acc_b_q     <= acc_b_d;
    nbits_q     <= nbits_d;
    kbits_q     <= kbits_d;
    cnt_q       <= cnt_d;
    out_lit_q   <= out_lit_d;
    out_level_q <= out_level_d;
    out_phase_q <= out_phase_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, out_level_q[3], out_level_q[2], out_level_q[1],
                          out_level_q[0], out_lit_q};
  assign m_axis_tuser  = out_phase_q;
  assign m_axis_tlast  = out_last_q;

  `include "row_column_wipe_pattern_macros.svh"

  `RCWP_ASSERT(a_dur_nonzero, state_q == S_CLIP, dur_q != '0, "phase duration is zero")
  `RCWP_ASSERT(a_clip_bound, state_q == S_MUL && cnt_q == '0, mcand_a_q <= mcand_b_q, "clip exceeds duration")
  `RCWP_ASSERT_NEXT(a_phase_hold, state_q != S_OUT && !in_fire, phase_q == $past(phase_q), "phase changed outside a transaction")
  `RCWP_ASSERT_NEXT(a_load_src, !m_valid_q && state_q != S_OUT, !m_valid_q, "result loaded outside output state")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rcwp_pkg::*;

  localparam int unsigned ITEM_GOAL    = 1050;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 400;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_SEC  = 64'd1_000_000;
  localparam logic [63:0] MAX_DUR  = 64'd65_535_000_000;
  localparam logic [63:0] SWEEP2   = 64'd1000 + 2 * MAX_DUR;

  typedef struct packed {
    logic       lit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic       phase;
    logic       fend;
  } pixel_out_t;

  typedef struct packed {
    logic        is_write;
    cfg_reg_e    reg_idx;
    logic [31:0] wval;
    req_type_e   kind;
    logic [63:0] now;
    logic [7:0]  prow;
    logic [7:0]  pcol;
    logic        flast;
    logic        typed;
    pixel_out_t  want;
  } plan_row_t;

  localparam pixel_out_t WHITE_ROWS = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0};
  localparam pixel_out_t WHITE_COLS = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0};
  localparam pixel_out_t DARK_ROWS  = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
  localparam pixel_out_t DARK_END   = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};
  localparam pixel_out_t DARK_COLS  = '{1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
  localparam pixel_out_t MIXED_LIT  = '{1'b1, 8'd1, 8'd0, 8'd255, 8'd128, 1'b0, 1'b0};
  localparam pixel_out_t BLACK_END  = '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  // sweep state and register copies
  logic [15:0] cfg_secs;
  logic [6:0]  cfg_pct;
  logic [7:0]  cfg_red;
  logic [7:0]  cfg_green;
  logic [7:0]  cfg_blue;
  logic [7:0]  cfg_white;
  logic [8:0]  cfg_rows;
  logic [8:0]  cfg_cols;
  logic        sweep_q;
  logic [63:0] phase_t0;

  pixel_out_t  pixel_due[$];
  plan_row_t   plan[$];
  int          err_count = 0;
  int          items_sent = 0;
  longint      cycle_cnt = 0;
  bit          long_hold = 1'b0;
  bit          no_idle = 1'b0;
  bit          settled = 1'b1;

  always #1 clk_i = ~clk_i;

  row_column_wipe_pattern dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [8:0] eff_dim(input logic [8:0] v, input int unsigned lim);
    if (v == 9'd0) return 9'd1;
    if (v > lim) return 9'(lim);
    return v;
  endfunction

  function automatic logic [7:0] scaled(input logic [7:0] level, input logic [6:0] pct);
    logic [15:0] prod;
    prod = 16'(level) * 16'(pct) + 16'd50;
    return 8'(prod / 16'd100);
  endfunction

  // advances the sweep by one transaction, returns 1 when a pixel comes out
  function automatic bit wipe_step(input req_type_e kind, input logic [63:0] now,
                                   input logic [7:0] prow, input logic [7:0] pcol,
                                   input logic flast, output pixel_out_t px);
    logic [63:0] dur;
    logic [63:0] elapsed;
    logic [63:0] clip;
    logic [63:0] span;
    logic [63:0] thr;
    logic [8:0]  rows;
    logic [8:0]  cols;
    logic [6:0]  pct;
    logic        phase;
    logic        lit;
    bit          hit;
    px = '0;
    if (kind == REQ_RESTART) begin
      sweep_q  = 1'b0;
      phase_t0 = now;
      return 1'b0;
    end
    dur     = 64'((cfg_secs == 16'd0) ? 16'd1 : cfg_secs) * 64'(US_PER_SECOND);
    elapsed = now - phase_t0;
    clip    = (elapsed >= dur) ? dur : elapsed;
    rows    = eff_dim(cfg_rows, MAX_ROWS);
    cols    = eff_dim(cfg_cols, MAX_COLS);
    phase   = sweep_q;
    span    = 64'(phase ? cols : rows);
    thr     = (clip * span) / dur;
    if (thr > span) thr = span;
    pct = (cfg_pct > 7'd100) ? 7'd100 : cfg_pct;
    hit = (9'(prow) < rows) && (9'(pcol) < cols);
    if (hit) begin
      lit      = phase ? (64'(pcol) < thr) : (64'(prow) >= thr);
      px.lit   = lit;
      px.red   = lit ? scaled(cfg_red, pct) : 8'd0;
      px.green = lit ? scaled(cfg_green, pct) : 8'd0;
      px.blue  = lit ? scaled(cfg_blue, pct) : 8'd0;
      px.white = lit ? scaled(cfg_white, pct) : 8'd0;
      px.phase = phase;
      px.fend  = flast;
    end
    if (flast && elapsed >= dur) begin
      phase_t0 = now;
      sweep_q  = ~phase;
    end
    return hit;
  endfunction

  function automatic void plan_write(input cfg_reg_e idx, input logic [31:0] val);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.wval     = val;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(input req_type_e kind, input logic [63:0] now,
                                    input logic [7:0] prow, input logic [7:0] pcol,
                                    input logic flast, input logic typed,
                                    input pixel_out_t want);
    plan_row_t r;
    r       = '0;
    r.kind  = kind;
    r.now   = now;
    r.prow  = prow;
    r.pcol  = pcol;
    r.flast = flast;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic logic [8:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      3:       return 9'($urandom_range(0, 511));
      4:       return 9'd255;
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    if (err_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic reg_write(input cfg_reg_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_DURATION: cfg_secs  = val[15:0];
      REG_BRIGHT:   cfg_pct   = val[6:0];
      REG_RED:      cfg_red   = val[7:0];
      REG_GREEN:    cfg_green = val[7:0];
      REG_BLUE:     cfg_blue  = val[7:0];
      REG_WHITE:    cfg_white = val[7:0];
      REG_ROWS:     cfg_rows  = val[8:0];
      REG_COLS:     cfg_cols  = val[8:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input req_type_e kind, input logic [63:0] now,
                           input logic [7:0] prow, input logic [7:0] pcol,
                           input logic flast, input logic typed, input pixel_out_t want);
    pixel_out_t px;
    bit         hit;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= flast;
    s_axis_tdata  <= {pcol, prow, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    settled = 1'b0;
    hit = wipe_step(kind, now, prow, pcol, flast, px);
    if (typed) pixel_due.push_back(want);
    else if (hit) pixel_due.push_back(px);
  endtask

  // drain every pending pixel, then give the serial unit time to go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    settled = 1'b1;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pixel_out_t got;
    pixel_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[16:9], m_axis_tdata[24:17],
             m_axis_tdata[32:25], m_axis_tuser, m_axis_tlast};
      if (pixel_due.size() == 0) begin
        log_mismatch("pixel transaction with none pending");
      end else begin
        want = pixel_due.pop_front();
        check_field("lit", got.lit, want.lit);
        check_field("red", got.red, want.red);
        check_field("green", got.green, want.green);
        check_field("blue", got.blue, want.blue);
        check_field("white", got.white, want.white);
        check_field("sweep_phase", got.phase, want.phase);
        check_field("frame_end", got.fend, want.fend);
      end
    end
  end

  // pixel sink
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          budget;
    int          fsize;
    int          roll;
    int          phase_no;
    logic [63:0] frame_t;
    logic [63:0] dur_now;
    logic [15:0] secs;
    logic [6:0]  bright;
    logic [7:0]  prow;
    logic [7:0]  pcol;

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_secs  = 16'd1;
    cfg_pct   = 7'd100;
    cfg_red   = 8'd255;
    cfg_green = 8'd255;
    cfg_blue  = 8'd255;
    cfg_white = 8'd0;
    cfg_rows  = 9'd1;
    cfg_cols  = 9'd1;
    sweep_q   = 1'b0;
    phase_t0  = '0;

    // 1x1 matrix, one second sweep
    plan_item(REQ_PIXEL, 64'd0, 8'd0, 8'd0, 1'b0, 1'b1, WHITE_ROWS);
    plan_item(REQ_PIXEL, ONE_SEC - 1, 8'd0, 8'd0, 1'b0, 1'b1, WHITE_ROWS);
    plan_item(REQ_PIXEL, ONE_SEC, 8'd0, 8'd0, 1'b1, 1'b1, DARK_END);
    plan_item(REQ_PIXEL, ONE_SEC, 8'd0, 8'd0, 1'b0, 1'b1, DARK_COLS);
    plan_item(REQ_PIXEL, 2 * ONE_SEC, 8'd0, 8'd0, 1'b0, 1'b1, WHITE_COLS);
    // outside the matrix, still flips on frame end
    plan_item(REQ_PIXEL, 2 * ONE_SEC, 8'd1, 8'd0, 1'b1, 1'b0, '0);
    plan_item(REQ_PIXEL, 2 * ONE_SEC, 8'd0, 8'd1, 1'b0, 1'b0, '0);
    // restart at the top of the time range, then wrap
    plan_item(REQ_RESTART, ALL_ONES, 8'd255, 8'd255, 1'b1, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd0, 8'd0, 8'd0, 1'b0, 1'b1, WHITE_ROWS);
    plan_item(REQ_PIXEL, ALL_ONES - 1, 8'd0, 8'd0, 1'b0, 1'b1, DARK_ROWS);
    plan_write(REG_BRIGHT, 32'd127);
    plan_write(REG_RED, 32'd1);
    plan_write(REG_GREEN, 32'd0);
    plan_write(REG_BLUE, 32'd255);
    plan_write(REG_WHITE, 32'd128);
    plan_item(REQ_PIXEL, ALL_ONES, 8'd0, 8'd0, 1'b0, 1'b1, MIXED_LIT);
    plan_write(REG_BRIGHT, 32'd0);
    plan_item(REQ_PIXEL, ALL_ONES, 8'd0, 8'd0, 1'b1, 1'b1, BLACK_END);
    plan_write(REG_BRIGHT, 32'd50);
    plan_write(REG_DURATION, 32'd0);
    plan_write(REG_ROWS, 32'd0);
    plan_write(REG_COLS, 32'd511);
    plan_item(REQ_PIXEL, ALL_ONES, 8'd0, 8'd255, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd499_999, 8'd0, 8'd128, 1'b0, 1'b0, '0);
    // longest sweep
    plan_write(REG_DURATION, 32'd65535);
    plan_write(REG_ROWS, 32'd511);
    plan_write(REG_COLS, 32'd0);
    plan_item(REQ_RESTART, 64'd1000, 8'd0, 8'd0, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd1000 + MAX_DUR / 2, 8'd255, 8'd0, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd1000 + MAX_DUR / 2, 8'd127, 8'd0, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd1000 + MAX_DUR, 8'd0, 8'd0, 1'b1, 1'b0, '0);
    plan_item(REQ_PIXEL, 64'd1000 + MAX_DUR + MAX_DUR / 2, 8'd0, 8'd0, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, SWEEP2, 8'd0, 8'd1, 1'b1, 1'b0, '0);
    // full 256x256 matrix, corner pixel around the threshold
    plan_write(REG_DURATION, 32'd2);
    plan_write(REG_ROWS, 32'd256);
    plan_write(REG_COLS, 32'd256);
    plan_write(REG_BRIGHT, 32'd100);
    plan_write(REG_RED, 32'd255);
    plan_write(REG_GREEN, 32'd255);
    plan_write(REG_WHITE, 32'd255);
    plan_item(REQ_PIXEL, SWEEP2 + 64'd1_999_999, 8'd255, 8'd255, 1'b1, 1'b0, '0);
    plan_item(REQ_PIXEL, SWEEP2 + 64'd2_000_000, 8'd255, 8'd255, 1'b1, 1'b0, '0);
    plan_item(REQ_PIXEL, SWEEP2 + 64'd2_000_000, 8'd255, 8'd255, 1'b0, 1'b0, '0);
    plan_item(REQ_PIXEL, SWEEP2 + 64'd4_000_000, 8'd255, 8'd255, 1'b0, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!settled) settle();
        reg_write(plan[i].reg_idx, plan[i].wval);
      end else begin
        send_item(plan[i].kind, plan[i].now, plan[i].prow, plan[i].pcol, plan[i].flast,
                  plan[i].typed, plan[i].want);
      end
    end

    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      if (!settled) settle();
      no_idle = (items_sent + 150 >= ITEM_GOAL);
      case ($urandom_range(0, 9))
        0:       secs = 16'd0;
        1:       secs = 16'd65535;
        2:       secs = 16'($urandom_range(6, 65534));
        default: secs = 16'($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 5))
        0:       bright = 7'd0;
        1:       bright = 7'd100;
        2:       bright = 7'd127;
        default: bright = 7'($urandom_range(0, 127));
      endcase
      reg_write(REG_DURATION, 32'(secs));
      reg_write(REG_BRIGHT, 32'(bright));
      reg_write(REG_RED, 32'(pick_level()));
      reg_write(REG_GREEN, 32'(pick_level()));
      reg_write(REG_BLUE, 32'(pick_level()));
      reg_write(REG_WHITE, 32'(pick_level()));
      reg_write(REG_ROWS, 32'(pick_count()));
      reg_write(REG_COLS, 32'(pick_count()));
      dur_now = 64'((cfg_secs == 16'd0) ? 16'd1 : cfg_secs) * 64'(US_PER_SECOND);
      if (phase_no == 2) long_hold = 1'b1;
      frame_t = {$urandom, $urandom};
      send_item(REQ_RESTART, frame_t, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      budget = $urandom_range(50, 110);
      while (budget > 0) begin
        frame_t = frame_t + ((dur_now * 64'($urandom_range(0, 400))) >> 10);
        fsize   = $urandom_range(1, 6);
        for (int k = 0; k < fsize; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 6) begin
            send_item(REQ_PIXEL, {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                      1'($urandom), 1'b0, '0);
          end else if (roll < 9) begin
            send_item(REQ_RESTART, $urandom_range(0, 1) ? frame_t : {$urandom, $urandom},
                      8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
          end else begin
            if (roll < 15) begin
              prow = 8'($urandom);
              pcol = 8'($urandom);
            end else begin
              prow = 8'($urandom_range(0, eff_dim(cfg_rows, MAX_ROWS) - 1));
              pcol = 8'($urandom_range(0, eff_dim(cfg_cols, MAX_COLS) - 1));
            end
            send_item(REQ_PIXEL, frame_t, prow, pcol, k == fsize - 1, 1'b0, '0);
          end
          budget--;
        end
      end
      phase_no++;
    end

    settle();
    if (err_count == 0 && pixel_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rcwp_pkg.sv
hdl/row_column_wipe_pattern.sv
tb/tb_top.sv
